// File: rtl/line_rasterizer_unit_defines.svh
// Assertion macros shared by the line rasterizer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LINE_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; used by lr_setup and line_rasterizer_unit.
package lr_pkg;

    localparam int DIM_BITS   = 11;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd800;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd600;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        CASE_VERT        = 3'd0,
        CASE_HORZ        = 3'd1,
        CASE_RISE_GENTLE = 3'd2,
        CASE_RISE_STEEP  = 3'd3,
        CASE_FALL_GENTLE = 3'd4,
        CASE_FALL_STEEP  = 3'd5
    } line_case_t;

endpackage

// File: rtl/line_rasterizer_unit.sv
// Line rasterizer top level: stream in/out, APB register port, walk state.
// Depends on lr_pkg, lr_setup and line_rasterizer_unit_defines.svh.
//
// Usage:
//   The slave stream carries one word per command. s_tuser selects the command:
//   load (0) takes two endpoints from s_tdata and produces nothing; advance (1)
//   produces the next pixel of the active segment, or nothing when no segment
//   is active. A load while a segment is active replaces it.
//   The master stream carries one pixel per word: m_tdata holds x and y,
//   m_tuser flags the pixel as on screen, m_tlast marks the final pixel.
//   An accepted advance is registered into the result register (m_tvalid), or
//   into the skid register while the receiver stalls. Throughput is one word
//   per cycle when not stalled (one add and compare on the decision per pixel).
//   A two-entry output buffer (result register plus skid register) lets one
//   more word be taken while the receiver stalls; s_tready drops only when
//   both entries are full.
//   Reset (aresetn low, synchronous) drops any active segment, empties the
//   output buffer and sets the screen size to 800 by 600. Write screen_width
//   (address 0) and screen_height (address 4) over APB only while idle.
`include "line_rasterizer_unit_defines.svh"

module line_rasterizer_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: x_start, y_start, x_end, y_end (low bit up), zero padded
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]  s_tdata,
    // s_tuser: func
    input  logic                               s_tuser,
    // m_tdata: pixel_x, pixel_y (low bit up), zero padded
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]  m_tdata,
    // m_tuser: visible
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                               pready
);

    localparam int DEC_BITS = COORD_BITS + 4;
    localparam int M_DATA_W = ((2*COORD_BITS+7)/8)*8;
    localparam int VIS_W    = COORD_BITS + lr_pkg::DIM_BITS + 1;

    // configuration
    logic [lr_pkg::DIM_BITS-1:0] width_reg, height_reg;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == lr_pkg::REG_SCREEN_HEIGHT)
                     ? {{(lr_pkg::APB_DATA_W-lr_pkg::DIM_BITS){1'b0}}, height_reg}
                     : {{(lr_pkg::APB_DATA_W-lr_pkg::DIM_BITS){1'b0}}, width_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lr_pkg::WIDTH_RESET;
            height_reg <= lr_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == lr_pkg::REG_SCREEN_HEIGHT) begin
                height_reg <= pwdata[lr_pkg::DIM_BITS-1:0];
            end else begin
                width_reg <= pwdata[lr_pkg::DIM_BITS-1:0];
            end
        end
    end

    // input unpack
    logic signed [COORD_BITS-1:0] in_x_start, in_y_start, in_x_end, in_y_end;

    assign in_x_start = s_tdata[COORD_BITS-1:0];
    assign in_y_start = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_x_end   = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_y_end   = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    logic [COORD_BITS-1:0] set_walk_x, set_walk_y, set_stop;
    logic [COORD_BITS:0]   set_major, set_minor;
    logic [DEC_BITS-1:0]   set_dec;
    lr_pkg::line_case_t    set_case;

    lr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x_start     (in_x_start),
        .y_start     (in_y_start),
        .x_end       (in_x_end),
        .y_end       (in_y_end),
        .walk_x      (set_walk_x),
        .walk_y      (set_walk_y),
        .stop_coord  (set_stop),
        .delta_major (set_major),
        .delta_minor (set_minor),
        .decision    (set_dec),
        .line_case   (set_case)
    );

    // walk state
    logic [COORD_BITS-1:0] walk_x_reg, walk_y_reg, stop_reg;
    logic [COORD_BITS-1:0] walk_x_next, walk_y_next;
    logic [COORD_BITS:0]   major_reg, minor_reg;
    logic [DEC_BITS-1:0]   dec_reg, dec_next;
    lr_pkg::line_case_t    case_reg;
    logic                  busy_reg;

    logic                  s_accept, push;
    logic [COORD_BITS-1:0] major_now;
    logic                  last_now, vis_now;
    logic [DEC_BITS-1:0]   maj_e, min_e;
    logic signed [VIS_W-1:0] px_e, py_e, w_e, h_e;

    assign s_accept = s_tvalid & s_tready;
    assign push     = s_accept & (s_tuser == lr_pkg::FUNC_ADVANCE) & busy_reg;
    assign maj_e    = {3'b000, major_reg};
    assign min_e    = {3'b000, minor_reg};

    always_comb begin
        case (case_reg)
            lr_pkg::CASE_VERT, lr_pkg::CASE_RISE_STEEP, lr_pkg::CASE_FALL_STEEP:
                major_now = walk_y_reg;
            default:
                major_now = walk_x_reg;
        endcase
    end

    assign last_now = (major_now == stop_reg);

    assign px_e = {{(VIS_W-COORD_BITS){walk_x_reg[COORD_BITS-1]}}, walk_x_reg};
    assign py_e = {{(VIS_W-COORD_BITS){walk_y_reg[COORD_BITS-1]}}, walk_y_reg};
    assign w_e  = {{(VIS_W-lr_pkg::DIM_BITS){1'b0}}, width_reg};
    assign h_e  = {{(VIS_W-lr_pkg::DIM_BITS){1'b0}}, height_reg};
    assign vis_now = (px_e >= VIS_W'(1)) && (px_e <= w_e)
                  && (py_e >= VIS_W'(1)) && (py_e <= h_e);

    always_comb begin
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        dec_next    = dec_reg;
        unique case (case_reg)
            lr_pkg::CASE_VERT: begin
                walk_y_next = walk_y_reg + 1'b1;
            end
            lr_pkg::CASE_HORZ: begin
                walk_x_next = walk_x_reg + 1'b1;
            end
            lr_pkg::CASE_RISE_GENTLE, lr_pkg::CASE_RISE_STEEP: begin
                if (dec_reg[DEC_BITS-1]) begin
                    dec_next = dec_reg + min_e;
                end else begin
                    dec_next = dec_reg + min_e - maj_e;
                    if (case_reg == lr_pkg::CASE_RISE_GENTLE) begin
                        walk_y_next = walk_y_reg + 1'b1;
                    end else begin
                        walk_x_next = walk_x_reg + 1'b1;
                    end
                end
                if (case_reg == lr_pkg::CASE_RISE_GENTLE) begin
                    walk_x_next = walk_x_reg + 1'b1;
                end else begin
                    walk_y_next = walk_y_reg + 1'b1;
                end
            end
            default: begin
                if (!dec_reg[DEC_BITS-1] && (dec_reg != '0)) begin
                    dec_next = dec_reg - (maj_e << 1) + (min_e << 1);
                    if (case_reg == lr_pkg::CASE_FALL_GENTLE) begin
                        walk_y_next = walk_y_reg - 1'b1;
                    end else begin
                        walk_x_next = walk_x_reg - 1'b1;
                    end
                end else begin
                    dec_next = dec_reg + (min_e << 1);
                end
                if (case_reg == lr_pkg::CASE_FALL_GENTLE) begin
                    walk_x_next = walk_x_reg + 1'b1;
                end else begin
                    walk_y_next = walk_y_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_x_reg <= '0;
            walk_y_reg <= '0;
            stop_reg   <= '0;
            major_reg  <= '0;
            minor_reg  <= '0;
            dec_reg    <= '0;
            case_reg   <= lr_pkg::CASE_VERT;
            busy_reg   <= 1'b0;
        end else if (s_accept) begin
            if (s_tuser == lr_pkg::FUNC_LOAD) begin
                walk_x_reg <= set_walk_x;
                walk_y_reg <= set_walk_y;
                stop_reg   <= set_stop;
                major_reg  <= set_major;
                minor_reg  <= set_minor;
                dec_reg    <= set_dec;
                case_reg   <= set_case;
                busy_reg   <= 1'b1;
            end else if (busy_reg) begin
                walk_x_reg <= walk_x_next;
                walk_y_reg <= walk_y_next;
                dec_reg    <= dec_next;
                if (last_now) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // output register and skid register
    logic                  out_valid_reg, skid_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg, skid_x_reg, skid_y_reg;
    logic                  out_vis_reg, out_last_reg, skid_vis_reg, skid_last_reg;

    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_x_reg    <= skid_x_reg;
                out_y_reg    <= skid_y_reg;
                out_vis_reg  <= skid_vis_reg;
                out_last_reg <= skid_last_reg;
            end else begin
                out_x_reg    <= walk_x_reg;
                out_y_reg    <= walk_y_reg;
                out_vis_reg  <= vis_now;
                out_last_reg <= last_now;
            end
        end
        if (push && (skid_valid_reg || (out_valid_reg && !m_tready))) begin
            skid_x_reg    <= walk_x_reg;
            skid_y_reg    <= walk_y_reg;
            skid_vis_reg  <= vis_now;
            skid_last_reg <= last_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-2*COORD_BITS){1'b0}}, out_y_reg, out_x_reg};
    assign m_tuser  = out_vis_reg;
    assign m_tlast  = out_last_reg;

    `LR_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg,
        "skid word held while output register empty")
    `LR_ASSERT_NEXT(a_pixel_emitted, aclk, aresetn, push, m_tvalid,
        "advance on active segment produced no word")
    `LR_ASSERT_NEXT(a_last_ends_line, aclk, aresetn, push && last_now, !busy_reg,
        "segment still active after its last pixel")
    `LR_ASSERT_NEXT(a_load_starts_line, aclk, aresetn,
        s_accept && (s_tuser == lr_pkg::FUNC_LOAD), busy_reg,
        "load did not start a segment")

endmodule

// File: rtl/lr_setup.sv
// Segment setup: orders endpoints, classifies the line and seeds the walk.
// Depends on lr_pkg; pure combinational logic used by line_rasterizer_unit.
module lr_setup #(
    parameter int COORD_BITS = 12
) (
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output logic        [COORD_BITS-1:0] walk_x,
    output logic        [COORD_BITS-1:0] walk_y,
    output logic        [COORD_BITS-1:0] stop_coord,
    output logic        [COORD_BITS:0]   delta_major,
    output logic        [COORD_BITS:0]   delta_minor,
    output logic        [COORD_BITS+3:0] decision,
    output lr_pkg::line_case_t           line_case
);

    logic                         swap;
    logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
    logic signed [COORD_BITS:0]   dx, dy, ady;

    assign swap = (x_end < x_start);
    assign x1   = swap ? x_end   : x_start;
    assign y1   = swap ? y_end   : y_start;
    assign x2   = swap ? x_start : x_end;
    assign y2   = swap ? y_start : y_end;
    assign dx   = {x2[COORD_BITS-1], x2} - {x1[COORD_BITS-1], x1};
    assign dy   = {y2[COORD_BITS-1], y2} - {y1[COORD_BITS-1], y1};
    assign ady  = -dy;

    always_comb begin
        walk_x      = x1;
        walk_y      = y1;
        stop_coord  = x2;
        delta_major = '0;
        delta_minor = '0;
        decision    = '0;
        line_case   = lr_pkg::CASE_VERT;
        if (dx == '0) begin
            line_case  = lr_pkg::CASE_VERT;
            walk_y     = (y1 < y2) ? y1 : y2;
            stop_coord = (y1 < y2) ? y2 : y1;
        end else if (dy == '0) begin
            line_case  = lr_pkg::CASE_HORZ;
            stop_coord = x2;
        end else if (dy > 0) begin
            if (dy <= dx) begin
                line_case   = lr_pkg::CASE_RISE_GENTLE;
                delta_major = dx;
                delta_minor = dy;
                stop_coord  = x2;
            end else begin
                line_case   = lr_pkg::CASE_RISE_STEEP;
                delta_major = dy;
                delta_minor = dx;
                stop_coord  = y2;
            end
            decision = {3'b000, delta_minor} - {3'b000, delta_major};
        end else begin
            if (ady <= dx) begin
                line_case   = lr_pkg::CASE_FALL_GENTLE;
                delta_major = dx;
                delta_minor = ady;
                stop_coord  = x2;
            end else begin
                line_case   = lr_pkg::CASE_FALL_STEEP;
                delta_major = ady;
                delta_minor = dx;
                walk_x      = x2;
                walk_y      = y2;
                stop_coord  = y1;
            end
            decision = {2'b00, delta_minor, 1'b0} - {3'b000, delta_major};
        end
    end

endmodule
